@@ hdl/abf_pkg.sv @@
// Shared types, constants and the CRC step function for the audio block framer.
// No dependencies; imported by every module in hdl/.
package abf_pkg;

  // samples per block and the derived frame constants
  localparam int SAMPLES_PER_BLOCK = 64;
  localparam int PIDX_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(SAMPLES_PER_BLOCK - 1);
  localparam logic [15:0] LEN_FIELD = 16'(4 + 4 * SAMPLES_PER_BLOCK);

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_FRAME_TYPE  = 2'd2;

  // queue depth between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one classified sample pair
  typedef struct packed {
    logic signed [15:0] in_sample;
    logic signed [15:0] out_sample;
    logic [31:0]        seq;
    logic               first;
    logic               last;
  } pair_t;

  // configuration values seen by the serializer
  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] frame_type;
  } cfg_t;

  // one byte into the crc, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/abf_front.sv @@
// Front end: accepts sample pairs and marks the first and last pair of each block.
// Depends on abf_pkg.
module abf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [63:0]    in_tdata,
  output logic           push,
  output abf_pkg::pair_t push_data,
  input  logic           q_full
);
  import abf_pkg::*;

  logic [PIDX_W-1:0] pidx_r;
  logic [PIDX_W-1:0] pidx_nxt;
  logic              is_last;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign is_last   = (pidx_r == PIDX_LAST);

  // classify the pair by its place in the block
  always_comb begin
    push_data.in_sample  = in_tdata[15:0];
    push_data.out_sample = in_tdata[31:16];
    push_data.seq        = in_tdata[63:32];
    push_data.first      = (pidx_r == '0);
    push_data.last       = is_last;
  end

  // pair index within the block
  always_comb begin
    pidx_nxt = pidx_r;
    if (push) begin
      pidx_nxt = is_last ? '0 : pidx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r <= '0;
    end else begin
      pidx_r <= pidx_nxt;
    end
  end

endmodule

@@ hdl/abf_queue.sv @@
// Short fifo of classified pairs between front end and serializer.
// Depends on abf_pkg.
module abf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  abf_pkg::pair_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output abf_pkg::pair_t q_data
);
  import abf_pkg::*;

  pair_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/abf_back.sv @@
// Back end: serializes each pair into wire bytes, one per cycle while out_tready is high, with running crc.
// Depends on abf_pkg.
module abf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  abf_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  abf_pkg::pair_t q_data,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);
  import abf_pkg::*;

  // byte positions within the frame
  localparam logic [3:0] POS_SYNC1  = 4'd0;
  localparam logic [3:0] POS_SYNC2  = 4'd1;
  localparam logic [3:0] POS_TYPE   = 4'd2;
  localparam logic [3:0] POS_LEN_LO = 4'd3;
  localparam logic [3:0] POS_LEN_HI = 4'd4;
  localparam logic [3:0] POS_SEQ0   = 4'd5;
  localparam logic [3:0] POS_SEQ1   = 4'd6;
  localparam logic [3:0] POS_SEQ2   = 4'd7;
  localparam logic [3:0] POS_SEQ3   = 4'd8;
  localparam logic [3:0] POS_IN_LO  = 4'd9;
  localparam logic [3:0] POS_IN_HI  = 4'd10;
  localparam logic [3:0] POS_OUT_LO = 4'd11;
  localparam logic [3:0] POS_OUT_HI = 4'd12;
  localparam logic [3:0] POS_CRC_LO = 4'd13;
  localparam logic [3:0] POS_CRC_HI = 4'd14;

  pair_t       cur_r, cur_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        orun_r, orun_nxt;
  logic        oframe_r, oframe_nxt;

  logic        adv;
  logic        emit;
  logic [3:0]  end_pos;
  logic        at_end;
  logic [7:0]  cur_byte;
  logic        covered;

  assign adv     = !ovalid_r || out_tready;
  assign emit    = busy_r && adv;
  assign end_pos = cur_r.last ? POS_CRC_HI : POS_OUT_HI;
  assign at_end  = (pos_r == end_pos);
  assign pop     = q_valid && (!busy_r || (emit && at_end));
  assign covered = (pos_r >= POS_TYPE) && (pos_r <= POS_OUT_HI);

  // byte at the current position
  always_comb begin
    case (pos_r)
      POS_SYNC1:  cur_byte = cfg.sync_first;
      POS_SYNC2:  cur_byte = cfg.sync_second;
      POS_TYPE:   cur_byte = cfg.frame_type;
      POS_LEN_LO: cur_byte = LEN_FIELD[7:0];
      POS_LEN_HI: cur_byte = LEN_FIELD[15:8];
      POS_SEQ0:   cur_byte = cur_r.seq[7:0];
      POS_SEQ1:   cur_byte = cur_r.seq[15:8];
      POS_SEQ2:   cur_byte = cur_r.seq[23:16];
      POS_SEQ3:   cur_byte = cur_r.seq[31:24];
      POS_IN_LO:  cur_byte = cur_r.in_sample[7:0];
      POS_IN_HI:  cur_byte = cur_r.in_sample[15:8];
      POS_OUT_LO: cur_byte = cur_r.out_sample[7:0];
      POS_OUT_HI: cur_byte = cur_r.out_sample[15:8];
      POS_CRC_LO: cur_byte = crc_r[7:0];
      POS_CRC_HI: cur_byte = crc_r[15:8];
      default:    cur_byte = 8'h00;
    endcase
  end

  // sequencer, crc and output register
  always_comb begin
    cur_nxt    = cur_r;
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    orun_nxt   = orun_r;
    oframe_nxt = oframe_r;

    if (emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_byte;
      orun_nxt   = at_end;
      oframe_nxt = (pos_r == POS_CRC_HI);
      pos_nxt    = pos_r + 1'b1;
      if (covered) begin
        crc_nxt = crc_byte((pos_r == POS_TYPE) ? CRC_INIT : crc_r, cur_byte);
      end
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (adv) begin
      ovalid_nxt = 1'b0;
    end

    if (pop) begin
      cur_nxt  = q_data;
      busy_nxt = 1'b1;
      pos_nxt  = q_data.first ? POS_SYNC1 : POS_IN_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      pos_r    <= POS_SYNC1;
      crc_r    <= CRC_INIT;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    obyte_r  <= obyte_nxt;
    orun_r   <= orun_nxt;
    oframe_r <= oframe_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = orun_r;
  assign out_tuser  = oframe_r;

endmodule

@@ hdl/audio_block_framer_crc16.sv @@
// Audio block framer with crc-16/ccitt-false trailer: one sample pair in, frame bytes out.
// An accepted pair passes the queue storage and the serializer's pair register; its bytes leave
// from the output byte register, one per cycle while out_tready is high: 4 bytes for a middle
// pair, 13 for a block's first pair, 6 for its last, 15 for a one-pair block.
// Reset (rst_n low, synchronous): queue emptied, block position 0, registers 0xAA/0x55/0x01.
module audio_block_framer_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [15:0] in_sample, [31:16] out_sample, [63:32] seq
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] wire_byte
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // [0] frame_last
);
  import abf_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  push;
  pair_t push_data;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  pair_t q_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SYNC_FIRST:  cfg_nxt.sync_first  = cfg_data;
        REG_SYNC_SECOND: cfg_nxt.sync_second = cfg_data;
        REG_FRAME_TYPE:  cfg_nxt.frame_type  = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= 8'hAA;
      cfg_r.sync_second <= 8'h55;
      cfg_r.frame_type  <= 8'h01;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end
  abf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // queue
  abf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // serializer
  abf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ tb/sv/audio_block_framer_crc16_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for audio_block_framer_crc16: stream bus in, frame bytes out.
// Depends on abf_pkg and the block only; a predictor class mirrors framing and crc-16.

// one expected byte on the result stream
typedef struct {
  logic [7:0] wire_byte;
  logic       run_last;
  logic       frame_last;
} wire_byte_t;

// predicts the frame bytes of each accepted item and checks the bytes that come out
class frame_byte_board;
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] frame_type;
  int         block_pos;
  logic [15:0] crc_run;
  wire_byte_t bytes_due[$];
  int         mismatches;

  function new();
    sync_first  = 8'hAA;
    sync_second = 8'h55;
    frame_type  = 8'h01;
    block_pos   = 0;
    crc_run     = 16'hFFFF;
    mismatches  = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      abf_pkg::REG_SYNC_FIRST:  sync_first  = val;
      abf_pkg::REG_SYNC_SECOND: sync_second = val;
      abf_pkg::REG_FRAME_TYPE:  frame_type  = val;
      default: ;
    endcase
  endfunction

  // shift one byte into the running crc, one bit at a time, msb first
  function void crc_shift_in(logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc_run[15] ^ b[i];
      crc_run = {crc_run[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
  endfunction

  function void push_byte(logic [7:0] b, bit covered, bit frame_end);
    wire_byte_t e;
    e.wire_byte  = b;
    e.run_last   = 1'b0;
    e.frame_last = frame_end;
    bytes_due.push_back(e);
    if (covered) crc_shift_in(b);
  endfunction

  function void push_le16(logic [15:0] v);
    push_byte(v[7:0], 1'b1, 1'b0);
    push_byte(v[15:8], 1'b1, 1'b0);
  endfunction

  // bytes caused by one accepted sample pair
  function void note_pair(logic [15:0] in_s, logic [15:0] out_s, logic [31:0] seq);
    logic [15:0] c;
    if (block_pos >= abf_pkg::SAMPLES_PER_BLOCK) block_pos = 0;
    if (block_pos == 0) begin
      crc_run = 16'hFFFF;
      push_byte(sync_first, 1'b0, 1'b0);
      push_byte(sync_second, 1'b0, 1'b0);
      push_byte(frame_type, 1'b1, 1'b0);
      push_le16(abf_pkg::LEN_FIELD);
      push_le16(seq[15:0]);
      push_le16(seq[31:16]);
    end
    push_le16(in_s);
    push_le16(out_s);
    if (block_pos == abf_pkg::SAMPLES_PER_BLOCK - 1) begin
      c = crc_run;
      push_byte(c[7:0], 1'b0, 1'b0);
      push_byte(c[15:8], 1'b0, 1'b1);
      block_pos = 0;
      crc_run = 16'hFFFF;
    end else begin
      block_pos++;
    end
    bytes_due[bytes_due.size()-1].run_last = 1'b1;
  endfunction

  function void check_byte(logic [7:0] b, logic run_last, logic frame_last);
    wire_byte_t e;
    if (bytes_due.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected wire byte %02h, nothing pending", $time, b);
      mismatches++;
      return;
    end
    e = bytes_due.pop_front();
    if (b !== e.wire_byte || run_last !== e.run_last || frame_last !== e.frame_last) begin
      if (mismatches < 10)
        $display("%0t: wire byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                 $time, e.wire_byte, e.run_last, e.frame_last, b, run_last, frame_last);
      mismatches++;
    end
  endfunction
endclass

module audio_block_framer_crc16_tb;
  import abf_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [15:0] in_sample, [31:16] out_sample, [63:32] seq
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] wire_byte
  logic        out_tlast;  // run_last
  logic        out_tuser;  // [0] frame_last

  frame_byte_board sb;
  bit long_hold_req;

  audio_block_framer_crc16 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor: predict on accepted items, check accepted bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_pair(in_tdata[15:0], in_tdata[31:16], in_tdata[63:32]);
      if (out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
    end
  end

  // receiver: stall patterns in segments, plus one long hold on request
  initial begin
    int hold_left;
    int seg_left;
    int stall_mode;
    int tick;
    hold_left = 0;
    seg_left = 0;
    stall_mode = 0;
    tick = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_tready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 160);
        end
        seg_left--;
        case (stall_mode)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: out_tready = (tick % 4 == 0);
          default: out_tready = (tick % 4 != 0);
        endcase
      end
    end
  end

  // cycle limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all_regs(input logic [7:0] s0, input logic [7:0] s1,
                                input logic [7:0] ft);
    write_reg(REG_SYNC_FIRST, s0);
    write_reg(REG_SYNC_SECOND, s1);
    write_reg(REG_FRAME_TYPE, ft);
  endtask

  // offer one sample pair and hold it until accepted
  task automatic send_pair(input logic [15:0] in_s, input logic [15:0] out_s,
                           input logic [31:0] seq);
    in_tdata  = {seq, out_s, in_s};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int n);
    in_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait until every predicted byte has come out
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.bytes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // random pairs in bursts; hold_at >= 0 starts the long receiver hold at that item
  task automatic send_random(input int n_pairs, input int hold_at);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_pairs) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n_pairs; k++) begin
        if (sent == hold_at) long_hold_req = 1'b1;
        send_pair(pick_sample(), pick_sample(), $urandom);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 40));
    end
  endtask

  initial begin
    sb = new();
    long_hold_req = 1'b0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SYNC_FIRST;
    cfg_data  = 8'h00;
    in_tvalid = 1'b0;
    in_tdata  = 64'h0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // directed pairs with reset register values; first pair carries the header
    send_pair(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    send_pair(16'h7FFF, 16'h8000, 32'h0000_0000);
    send_pair(16'h0000, 16'h0000, 32'h1234_5678);
    send_pair(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    sender_gap(3);
    send_pair(16'h0001, 16'hFFFE, 32'h8000_0001);
    send_pair(16'h00FF, 16'hFF00, 32'h0000_0000);
    send_pair(16'h5555, 16'hAAAA, 32'hA5A5_5A5A);
    send_pair(16'hAAAA, 16'h5555, 32'h5A5A_A5A5);
    send_pair(16'h0080, 16'hFF7F, 32'h0000_FFFF);
    send_pair(16'h8001, 16'h7FFE, 32'hFFFF_0000);
    drain_results();

    // extreme register values mid-frame; the unused index must be ignored
    write_all_regs(8'h00, 8'hFF, 8'h00);
    write_reg(REG_UNUSED, 8'h5A);
    send_random(90, 20);
    drain_results();

    write_all_regs(8'hFF, 8'h00, 8'hFF);
    send_random(90, -1);
    drain_results();

    write_all_regs(8'($urandom), 8'($urandom), 8'($urandom));
    write_reg(REG_UNUSED, 8'hFF);
    send_random(90, -1);
    drain_results();

    // back to the usual framing
    write_all_regs(8'hAA, 8'h55, 8'h01);
    send_random(82, -1);
    drain_results();
    repeat (20) @(negedge clk);

    if (sb.mismatches == 0 && sb.bytes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
